// ----- src/dpjq_pkg.sv -----
package dpjq_pkg;

    // Default queue depth and register reset value.
    localparam int unsigned DPJQ_DEPTH = 16;
    localparam logic [15:0] FLUSH_PRIORITY_RESET = 16'd9999;

    // Request codes.
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_TAKE  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Job types.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SAVE = 1'b1;

    // Cell move commands.
    typedef logic [1:0] t_mv;
    localparam t_mv MV_HOLD  = 2'd0;
    localparam t_mv MV_LEFT  = 2'd1;
    localparam t_mv MV_RIGHT = 2'd2;
    localparam t_mv MV_NEW   = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [15:0] prio;
        logic [7:0]  volume;
        logic [15:0] chunk;
    } t_job;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        job_kind;
        logic [15:0] job_priority;
        logic [7:0]  volume_id;
        logic [15:0] chunk_id;
        logic [3:0]  active_loads;
        logic [3:0]  active_saves;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        job_valid;
        logic        out_kind;
        logic [15:0] out_priority;
        logic [7:0]  out_volume;
        logic [15:0] out_chunk;
    } t_rsp;

    // Compare results that one cell reports against the current key.
    typedef struct packed {
        logic key_eq;
        logic prio_gt;
        logic kind;
    } t_cell_flags;

endpackage

// ----- src/dedup_priority_job_queue_core.sv -----
// Job queue held in a row of cells, one job per cell, highest priority first
// except where a flush has moved jobs to the front. A transaction is accepted
// when start is high and busy is low; the result comes back as a one-cycle
// strobe on o_rsp_valid and cannot be held off. An add that is dropped as a
// duplicate passes through the scan state only; one that is inserted or dropped
// for a full queue goes through scan and insert, and one that replaces an entry
// through scan, removal and insert. A take goes through scan and removal, or
// scan only on an empty queue; an unknown request through scan only. A flush
// walks the queue one cell per cycle, rotating each matching job to the
// front. Busy drops in the cycle that shows the result, so the next
// transaction can be accepted at the edge that takes it. Configuration writes
// to the flush priority go in directly through i_cfg_we.
module dedup_priority_job_queue_core #(
    parameter int unsigned QUEUE_DEPTH = dpjq_pkg::DPJQ_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dpjq_pkg::t_req i_req,
    output logic           o_rsp_valid,
    output dpjq_pkg::t_rsp o_rsp,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata
);
    import dpjq_pkg::*;

    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_REMOVE = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_k, n_k;
    logic [15:0]            r_flush_prio;
    t_req                   r_req;
    t_job                   r_sel, n_sel;
    logic [QUEUE_DEPTH-1:0] r_rm, n_rm;
    logic                   r_rsp_valid, n_rsp_valid;
    t_rsp                   r_rsp, n_rsp;

    t_job                   w_entry [QUEUE_DEPTH];
    t_cell_flags            w_flags [QUEUE_DEPTH];
    t_mv                    w_mv    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid, w_hit, w_pf, w_first, w_ins, w_ip;
    t_job                   w_key, w_new, w_first_job, w_walk;
    logic                   w_fav, w_fhit;

    // Key for the cell compares.
    always_comb begin
        w_key.kind   = r_req.job_kind;
        w_key.prio   = r_req.job_priority;
        w_key.volume = r_req.volume_id;
        w_key.chunk  = r_req.chunk_id;
    end

    assign w_fav = (r_req.active_saves > r_req.active_loads) ? KIND_LOAD : KIND_SAVE;

    // Per-cell hit flags and the prefix chains that find the first hit and the
    // insert position. After a flush the order need not be sorted, so the insert
    // position is the first cell whose priority is lower than the new job.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_valid[i] = (CW'(i) < r_count);
            if (r_req.req_type == REQ_TAKE) begin
                w_hit[i] = w_valid[i] && (w_flags[i].kind == w_fav);
            end else begin
                w_hit[i] = w_valid[i] && w_flags[i].key_eq;
            end
            w_ins[i] = (w_valid[i] && w_flags[i].prio_gt) || (CW'(i) == r_count);
        end
        w_pf[0]    = w_hit[0];
        w_first[0] = w_hit[0];
        w_ip[0]    = w_ins[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            w_pf[i]    = w_pf[i-1] | w_hit[i];
            w_first[i] = w_hit[i] & ~w_pf[i-1];
            w_ip[i]    = w_ip[i-1] | w_ins[i];
        end
    end

    // Entry of the first hit, through an AND-OR select.
    always_comb begin
        w_first_job = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_first[i]) begin
                w_first_job = w_first_job | w_entry[i];
            end
        end
    end

    // Entry under the flush walk pointer.
    always_comb begin
        w_walk      = w_entry[r_k[IW-1:0]];
        w_walk.prio = r_flush_prio;
        w_fhit      = (r_k < r_count) && (w_entry[r_k[IW-1:0]].volume == r_req.volume_id);
    end

    assign w_new = (r_state == S_FLUSH) ? w_walk : w_key;

    // Move command for every cell.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_mv[i] = MV_HOLD;
            if (r_state == S_REMOVE) begin
                if (r_rm[i]) begin
                    w_mv[i] = MV_RIGHT;
                end
            end else if (r_state == S_INSERT) begin
                if (r_count != CW'(QUEUE_DEPTH)) begin
                    if (i > 0 && w_ip[(i > 0) ? i - 1 : 0]) begin
                        w_mv[i] = MV_LEFT;
                    end else if (w_ip[i]) begin
                        w_mv[i] = MV_NEW;
                    end
                end
            end else if (r_state == S_FLUSH) begin
                if (w_fhit && (CW'(i) <= r_k)) begin
                    w_mv[i] = (i == 0) ? MV_NEW : MV_LEFT;
                end
            end
        end
    end

    // The row of cells.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        dpjq_cell u_cell (
            .i_clk   (i_clk),
            .i_mv    (w_mv[g]),
            .i_left  (w_entry[(g > 0) ? g - 1 : g]),
            .i_right (w_entry[(g < QUEUE_DEPTH - 1) ? g + 1 : g]),
            .i_new   (w_new),
            .i_key   (w_key),
            .o_entry (w_entry[g]),
            .o_flags (w_flags[g])
        );
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_sel       = r_sel;
        n_rm        = r_rm;
        n_rsp_valid = 1'b0;
        n_rsp       = r_rsp;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_rsp = '0;
                case (r_req.req_type)
                    REQ_ADD: begin
                        if (w_pf[QUEUE_DEPTH-1] && (w_first_job.kind == r_req.job_kind)) begin
                            if (r_req.job_priority > w_first_job.prio) begin
                                n_rm    = w_pf;
                                n_state = S_REMOVE;
                            end else begin
                                n_rsp.status = ST_DUP;
                                n_rsp_valid  = 1'b1;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            n_state = S_INSERT;
                        end
                    end
                    REQ_FLUSH: begin
                        n_k     = '0;
                        n_state = S_FLUSH;
                    end
                    REQ_TAKE: begin
                        if (r_count == '0) begin
                            n_rsp.status = ST_EMPTY;
                            n_rsp_valid  = 1'b1;
                            n_state      = S_IDLE;
                        end else if (w_pf[QUEUE_DEPTH-1]) begin
                            n_sel   = w_first_job;
                            n_rm    = w_pf;
                            n_state = S_REMOVE;
                        end else begin
                            n_sel   = w_entry[0];
                            n_rm    = '1;
                            n_state = S_REMOVE;
                        end
                    end
                    default: begin
                        n_rsp_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                endcase
            end
            S_REMOVE: begin
                n_count = r_count - CW'(1);
                if (r_req.req_type == REQ_ADD) begin
                    n_state = S_INSERT;
                end else begin
                    n_rsp.status       = ST_DONE;
                    n_rsp.job_valid    = 1'b1;
                    n_rsp.out_kind     = r_sel.kind;
                    n_rsp.out_priority = r_sel.prio;
                    n_rsp.out_volume   = r_sel.volume;
                    n_rsp.out_chunk    = r_sel.chunk;
                    n_rsp_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_INSERT: begin
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.status = ST_DONE;
                    n_count      = r_count + CW'(1);
                end
                n_rsp_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_FLUSH: begin
                if (r_k == r_count) begin
                    n_rsp.status = ST_DONE;
                    n_rsp_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_rsp_valid  <= 1'b0;
            r_flush_prio <= FLUSH_PRIORITY_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_we) begin
                r_flush_prio <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_sel <= n_sel;
        r_rm  <= n_rm;
        r_rsp <= n_rsp;
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ----- src/dpjq_cell.sv -----
module dpjq_cell (
    input  logic                  i_clk,
    input  dpjq_pkg::t_mv         i_mv,
    input  dpjq_pkg::t_job        i_left,
    input  dpjq_pkg::t_job        i_right,
    input  dpjq_pkg::t_job        i_new,
    input  dpjq_pkg::t_job        i_key,
    output dpjq_pkg::t_job        o_entry,
    output dpjq_pkg::t_cell_flags o_flags
);
    import dpjq_pkg::*;

    t_job r_entry;
    t_job n_entry;

    // Pick the next entry from this cell, a neighbor or the new job.
    always_comb begin
        unique case (i_mv)
            MV_HOLD:  n_entry = r_entry;
            MV_LEFT:  n_entry = i_left;
            MV_RIGHT: n_entry = i_right;
            MV_NEW:   n_entry = i_new;
            default:  n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // Local compares against the key of the current transaction.
    always_comb begin
        o_flags.key_eq  = (r_entry.volume == i_key.volume) && (r_entry.chunk == i_key.chunk);
        o_flags.prio_gt = (i_key.prio > r_entry.prio);
        o_flags.kind    = r_entry.kind;
    end

    assign o_entry = r_entry;

endmodule

// ----- src/dpjq_checker.sv -----
module dpjq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_rsp_valid,
    input dpjq_pkg::t_rsp o_rsp
);
    import dpjq_pkg::*;

    // An accepted transaction makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Each result follows a busy cycle.
    a_rsp_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> $past(busy))
        else $error("result without a transaction in flight");

    // Results never come back to back.
    a_rsp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |=> !o_rsp_valid)
        else $error("two results in consecutive cycles");

    // A handed-out job always carries the done status.
    a_job_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.job_valid) |-> (o_rsp.status == ST_DONE))
        else $error("job handed out with a failure status");

    // Without a job, the job fields are zero.
    a_no_job_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.job_valid) |->
            (o_rsp.out_kind == 1'b0 && o_rsp.out_priority == '0 &&
             o_rsp.out_volume == '0 && o_rsp.out_chunk == '0))
        else $error("job fields set without a job");

endmodule

bind dedup_priority_job_queue_core dpjq_checker u_dpjq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dpjq_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 2 * DPJQ_DEPTH + 16;
    localparam int unsigned RANDOM_ITEMS   = 1500;
    localparam logic [1:0]  REQ_UNKNOWN    = 2'd3;

    // One queued job as the scoreboard keeps it.
    typedef struct packed {
        logic        kind;
        logic [15:0] prio;
        logic [7:0]  vol;
        logic [15:0] chunk;
    } t_queued_job;

    // One directed row: the request and, where it is obvious, the response.
    typedef struct packed {
        t_req req;
        logic has_rsp;
        t_rsp rsp;
    } t_job_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_rsp_valid;
    t_rsp        o_rsp;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    t_queued_job job_list[$];
    logic [15:0] flush_prio_shadow = FLUSH_PRIORITY_RESET;
    t_rsp        pending_rsp[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;

    dedup_priority_job_queue_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Build a request from its fields.
    function automatic t_req make_req(logic [1:0] rt, logic kind, logic [15:0] prio,
                                      logic [7:0] vol, logic [15:0] chunk,
                                      logic [3:0] loads, logic [3:0] saves);
        t_req r;
        r.req_type     = rt;
        r.job_kind     = kind;
        r.job_priority = prio;
        r.volume_id    = vol;
        r.chunk_id     = chunk;
        r.active_loads = loads;
        r.active_saves = saves;
        return r;
    endfunction

    // Apply one request to the shadow queue and return the response it yields.
    function automatic t_rsp queue_response(t_req r);
        t_rsp        rsp;
        t_queued_job nj;
        t_queued_job moved[$];
        t_queued_job kept[$];
        t_queued_job got;
        int          hit;
        int          pos;
        logic        fav;
        rsp = '0;
        nj.kind  = r.job_kind;
        nj.prio  = r.job_priority;
        nj.vol   = r.volume_id;
        nj.chunk = r.chunk_id;
        case (r.req_type)
            REQ_ADD: begin
                hit = -1;
                foreach (job_list[i]) begin
                    if (hit < 0 && job_list[i].vol == nj.vol && job_list[i].chunk == nj.chunk)
                        hit = i;
                end
                if (hit >= 0 && job_list[hit].kind == nj.kind) begin
                    if (nj.prio > job_list[hit].prio) begin
                        job_list.delete(hit);
                    end else begin
                        rsp.status = ST_DUP;
                        return rsp;
                    end
                end
                if (job_list.size() >= DPJQ_DEPTH) begin
                    rsp.status = ST_FULL;
                    return rsp;
                end
                pos = job_list.size();
                for (int i = job_list.size() - 1; i >= 0; i--) begin
                    if (nj.prio > job_list[i].prio)
                        pos = i;
                end
                job_list.insert(pos, nj);
            end
            REQ_FLUSH: begin
                // Matching jobs go to the front in reverse walk order.
                foreach (job_list[i]) begin
                    if (job_list[i].vol == nj.vol) begin
                        got = job_list[i];
                        got.prio = flush_prio_shadow;
                        moved.insert(0, got);
                    end else begin
                        kept.insert(kept.size(), job_list[i]);
                    end
                end
                job_list = {moved, kept};
            end
            REQ_TAKE: begin
                if (job_list.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    fav = (r.active_saves > r.active_loads) ? KIND_LOAD : KIND_SAVE;
                    pos = -1;
                    foreach (job_list[i]) begin
                        if (pos < 0 && job_list[i].kind == fav)
                            pos = i;
                    end
                    if (pos < 0)
                        pos = 0;
                    got = job_list[pos];
                    job_list.delete(pos);
                    rsp.job_valid    = 1'b1;
                    rsp.out_kind     = got.kind;
                    rsp.out_priority = got.prio;
                    rsp.out_volume   = got.vol;
                    rsp.out_chunk    = got.chunk;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // Random request: mostly a few volumes and chunks so duplicates are common.
    function automatic t_req random_req(int unsigned add_weight);
        int unsigned pick;
        logic [1:0]  rt;
        logic [7:0]  vol;
        logic [15:0] chunk;
        logic [15:0] prio;
        pick = $urandom_range(0, 99);
        if (pick < add_weight)
            rt = REQ_ADD;
        else if (pick < add_weight + 8)
            rt = REQ_FLUSH;
        else if (pick < 96)
            rt = REQ_TAKE;
        else
            rt = REQ_UNKNOWN;
        vol   = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        chunk = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        prio  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        return make_req(rt, 1'($urandom), prio, vol, chunk,
                        4'($urandom), 4'($urandom));
    endfunction

    // Present a request and hold it until the block takes it. Call just after an edge.
    task automatic send_req(t_req r, logic has_rsp, t_rsp typed_rsp);
        t_rsp predicted;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predicted = queue_response(r);
        pending_rsp.insert(pending_rsp.size(), has_rsp ? typed_rsp : predicted);
    endtask

    // Sender pacing: bursts of back-to-back transactions with random gaps.
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Wait until every outstanding response has arrived and the block is quiet.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_flush_prio(logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        flush_prio_shadow = value;
    endtask

    // Compare each response against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid) begin
            if (pending_rsp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response %p", o_rsp);
            end else begin
                t_rsp want;
                want = pending_rsp[0];
                pending_rsp.delete(0);
                if (o_rsp.status !== want.status || o_rsp.job_valid !== want.job_valid ||
                    o_rsp.out_kind !== want.out_kind ||
                    o_rsp.out_priority !== want.out_priority ||
                    o_rsp.out_volume !== want.out_volume ||
                    o_rsp.out_chunk !== want.out_chunk) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("response mismatch: expected %p, got %p", want, o_rsp);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_rsp_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_job_row    rows[$];
        t_rsp        none;
        t_rsp        done_rsp;
        t_rsp        dup_rsp;
        t_rsp        full_rsp;
        t_rsp        empty_rsp;
        logic [15:0] phase_prio[4];

        none      = '0;
        done_rsp  = '0;
        dup_rsp   = '0;
        full_rsp  = '0;
        empty_rsp = '0;
        dup_rsp.status   = ST_DUP;
        full_rsp.status  = ST_FULL;
        empty_rsp.status = ST_EMPTY;

        // Directed rows: empty take, extremes, duplicates, replacement, flush, fill.
        rows.insert(rows.size(), '{make_req(REQ_TAKE, '0, '0, '0, '0, 4'hF, 4'h0),
                                   1'b1, empty_rsp});
        rows.insert(rows.size(), '{make_req(REQ_ADD, KIND_LOAD, 16'hFFFF, 8'hFF, 16'hFFFF,
                                            '0, '0), 1'b1, done_rsp});
        rows.insert(rows.size(), '{make_req(REQ_ADD, KIND_LOAD, 16'hFFFF, 8'hFF, 16'hFFFF,
                                            '0, '0), 1'b1, dup_rsp});
        rows.insert(rows.size(), '{make_req(REQ_ADD, KIND_SAVE, 16'h0000, 8'hFF, 16'hFFFF,
                                            '0, '0), 1'b1, done_rsp});
        rows.insert(rows.size(), '{make_req(REQ_ADD, KIND_LOAD, 16'h0000, 8'h00, 16'h0000,
                                            '0, '0), 1'b1, done_rsp});
        rows.insert(rows.size(), '{make_req(REQ_ADD, KIND_LOAD, 16'h0005, 8'h00, 16'h0000,
                                            '0, '0), 1'b0, none});
        rows.insert(rows.size(), '{make_req(REQ_FLUSH, '0, '0, 8'h00, '0, '0, '0),
                                   1'b1, done_rsp});
        rows.insert(rows.size(), '{make_req(REQ_FLUSH, '0, '0, 8'h77, '0, '0, '0),
                                   1'b1, done_rsp});
        rows.insert(rows.size(), '{make_req(REQ_UNKNOWN, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF,
                                            4'hF, 4'hF), 1'b1, done_rsp});
        for (int i = 0; i < DPJQ_DEPTH - 3; i++)
            rows.insert(rows.size(), '{make_req(REQ_ADD, 1'(i), 16'(i * 7), 8'h10, 16'(i),
                                                '0, '0), 1'b0, none});
        rows.insert(rows.size(), '{make_req(REQ_ADD, KIND_SAVE, 16'h1234, 8'h20, 16'h0001,
                                            '0, '0), 1'b1, full_rsp});
        rows.insert(rows.size(), '{make_req(REQ_ADD, KIND_LOAD, 16'hFFFF, 8'h10, 16'h0000,
                                            '0, '0), 1'b0, none});
        rows.insert(rows.size(), '{make_req(REQ_FLUSH, '0, '0, 8'h10, '0, '0, '0),
                                   1'b1, done_rsp});
        rows.insert(rows.size(), '{make_req(REQ_TAKE, '0, '0, '0, '0, 4'h0, 4'hF),
                                   1'b0, none});
        rows.insert(rows.size(), '{make_req(REQ_TAKE, '0, '0, '0, '0, 4'hF, 4'h0),
                                   1'b0, none});
        rows.insert(rows.size(), '{make_req(REQ_TAKE, '0, '0, '0, '0, 4'h7, 4'h7),
                                   1'b0, none});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            pace_sender();
            send_req(rows[i].req, rows[i].has_rsp, rows[i].rsp);
        end
        drain();

        // Random phases, each under its own flush priority.
        phase_prio[0] = 16'h0000;
        phase_prio[1] = 16'hFFFF;
        phase_prio[2] = 16'($urandom);
        phase_prio[3] = FLUSH_PRIORITY_RESET;
        for (int ph = 0; ph < 4; ph++) begin
            write_flush_prio(phase_prio[ph]);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                pace_sender();
                send_req(random_req((ph % 2 == 0) ? 55 : 40), 1'b0, none);
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/dpjq_pkg.sv
src/dpjq_cell.sv
src/dedup_priority_job_queue_core.sv
src/dpjq_checker.sv
tb/testbench.sv
